// ----- design/rsc_pkg.sv -----
// Shared types and constants for the resistance settle calibrator.
package rsc_pkg;

  localparam int unsigned ADC_BITS_DEF = 10;
  localparam int unsigned SAMPLE_W     = 10;
  localparam int unsigned LOAD_W       = 24;
  localparam int unsigned STABLE_W     = 8;
  localparam int unsigned RES_W        = 34;
  localparam int unsigned RUN_W        = 9;
  localparam int unsigned SEC_W        = 16;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned CFG_IDX_W    = 1;

  localparam logic [RES_W-1:0]    RES_MAX      = '1;
  localparam logic [RUN_W-1:0]    RUN_MAX      = '1;
  localparam logic [SEC_W-1:0]    SEC_MAX      = '1;
  localparam logic [LOAD_W-1:0]   LOAD_RES_RST = 24'd10000;
  localparam logic [STABLE_W-1:0] STABLE_RST   = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOAD_RES = 1'b0,
    CFG_STABLE   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                restart;
  } in_item_t;

  typedef struct packed {
    logic [RES_W-1:0] resistance;
    logic             done_res;
    logic [RES_W-1:0] base_resistance;
    logic [SEC_W-1:0] settle_seconds;
  } out_item_t;

  // Classified sample handed from front to back.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                zero;
    logic                restart;
  } task_t;

  typedef struct packed {
    logic [LOAD_W-1:0]   load_res;
    logic [STABLE_W-1:0] stable_needed;
  } cfg_t;

endpackage

// ----- design/rsc_front.sv -----
// Front end: accept samples, clamp them to full scale and flag zero readings.
module rsc_front import rsc_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_i,
  input  logic     full_i,
  output logic     push_o,
  output task_t    entry_o
);

  localparam logic [ADC_BITS-1:0] FS = '1;

  logic [SAMPLE_W-1:0] clamped;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  // Clamp readings above full scale; a no-op when the converter is 10 bits or wider.
  always_comb begin
    if ({{SAMPLE_W{1'b0}}, in_i.sample} > {{SAMPLE_W{1'b0}}, SAMPLE_W'(FS)}
        && ADC_BITS < SAMPLE_W) begin
      clamped = SAMPLE_W'(FS);
    end else begin
      clamped = in_i.sample;
    end
    entry_o.sample  = clamped;
    entry_o.zero    = (clamped == '0);
    entry_o.restart = in_i.restart;
  end

endmodule

// ----- design/rsc_queue.sv -----
// Short queue of classified samples between front and back.
module rsc_queue import rsc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  task_t entry_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output task_t entry_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  task_t              slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d;
  logic [PTR_W-1:0]   rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = slots_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= entry_i;
    end
  end

endmodule

// ----- design/rsc_back.sv -----
// Back end: multiply, restoring divide, stability test and result register.
module rsc_back import rsc_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      empty_i,
  output logic      pop_o,
  input  task_t     entry_i,
  input  cfg_t      cfg_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int unsigned PROD_W = ADC_BITS + LOAD_W;
  localparam int unsigned CNT_W  = $clog2(PROD_W);
  localparam int unsigned D50_W  = RES_W + 6;
  localparam logic [ADC_BITS-1:0] FS = '1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_SAT  = 5'b01000,
    S_EVAL = 5'b10000
  } back_state_e;

  back_state_e         state_q, state_d;
  task_t               task_q;
  logic [PROD_W-1:0]   quot_q, quot_d;
  logic [SAMPLE_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RES_W-1:0]    rs_q, diff_q;

  logic [RES_W-1:0]    ref_q, ref_d;
  logic [RUN_W-1:0]    run_q, run_d;
  logic [SEC_W-1:0]    sec_q, sec_d;
  logic                fin_q, fin_d;

  logic                out_valid_q;
  out_item_t           out_q;

  logic [ADC_BITS-1:0] fs_diff;
  logic [PROD_W-1:0]   product;
  logic [SAMPLE_W:0]   rem_shl;
  logic                rem_ge;
  logic                q_sat;
  logic [RES_W-1:0]    rs_sat;
  logic [RES_W-1:0]    ref_e;
  logic [RUN_W-1:0]    run_e;
  logic [SEC_W-1:0]    sec_e;
  logic                fin_e;
  logic [D50_W-1:0]    diff_ext, diff50;
  logic                unstable;
  logic                out_free;
  logic                eval_fire;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign eval_fire = (state_q == S_EVAL) && out_free;
  assign pop_o     = (state_q == S_IDLE) && !empty_i;

  // Numerator (FS - s) * RL.
  assign fs_diff = FS - ADC_BITS'(task_q.sample);
  assign product = PROD_W'(fs_diff) * PROD_W'(cfg_i.load_res);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_shl = {rem_q, quot_q[PROD_W-1]};
  assign rem_ge  = rem_shl >= {1'b0, task_q.sample};

  assign q_sat  = 64'(quot_q) > 64'(RES_MAX);
  assign rs_sat = q_sat ? RES_MAX : RES_W'(quot_q);

  // Restart clears the state before this sample is judged.
  assign ref_e = task_q.restart ? '0 : ref_q;
  assign run_e = task_q.restart ? '0 : run_q;
  assign sec_e = task_q.restart ? '0 : sec_q;
  assign fin_e = task_q.restart ? 1'b0 : fin_q;

  assign diff_ext = D50_W'(diff_q);
  assign diff50   = (diff_ext << 5) + (diff_ext << 4) + (diff_ext << 1);
  assign unstable = diff50 > D50_W'(rs_q);

  always_comb begin
    state_d = state_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          state_d = entry_i.zero ? S_SAT : S_MUL;
          quot_d  = '0;
        end
      end
      S_MUL: begin
        quot_d  = product;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        quot_d = {quot_q[PROD_W-2:0], rem_ge};
        rem_d  = rem_ge ? SAMPLE_W'(rem_shl - {1'b0, task_q.sample}) : rem_shl[SAMPLE_W-1:0];
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ref_d = ref_e;
    run_d = run_e;
    sec_d = sec_e;
    fin_d = fin_e;
    if (!fin_e) begin
      if (unstable) begin
        ref_d = rs_q;
        run_d = '0;
      end else if (run_e != RUN_MAX) begin
        run_d = run_e + 1'b1;
      end
      if (sec_e != SEC_MAX) begin
        sec_d = sec_e + 1'b1;
      end
      fin_d = run_d > RUN_W'(cfg_i.stable_needed);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_q       <= '0;
      run_q       <= '0;
      sec_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (eval_fire) begin
        ref_q       <= ref_d;
        run_q       <= run_d;
        sec_q       <= sec_d;
        fin_q       <= fin_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      task_q <= entry_i;
    end
    quot_q <= quot_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    if (state_q == S_SAT) begin
      rs_q   <= rs_sat;
      diff_q <= (ref_e > rs_sat) ? (ref_e - rs_sat) : (rs_sat - ref_e);
    end
    if (eval_fire) begin
      out_q.resistance      <= rs_q;
      out_q.done_res        <= fin_d;
      out_q.base_resistance <= ref_d;
      out_q.settle_seconds  <= sec_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ----- design/resistance_settle_calibrator.sv -----
// Top level of the resistance settle calibrator.
// Each input transaction carries one converter sample; the block converts it to sensor
// resistance floor((FS - s) * load_resistance / s) in ohms (0 for a zero sample, clamped
// at 2^34 - 1), tests it against the running reference with the 2 percent rule
// 50*|ref - rs| <= rs, and returns one result transaction per sample with the resistance,
// the done flag, the reference (R0 once done) and the saturating sample count. After done,
// samples leave the state alone until one arrives with restart set. The back end takes one
// sample at a time and works through it in steps: a pop, a multiply, the restoring divider,
// which retires one quotient bit per cycle and sets the rate, a saturate step and an
// evaluate step, which waits while a stalled result is held. A zero sample skips the
// multiply and divide. The front accepts into a two-entry queue while the back is busy,
// and the result register holds a finished result while the back continues. Write
// configuration only while the block is idle.
module resistance_settle_calibrator import rsc_pkg::*; #(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LOAD_W-1:0]    cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  q_full, q_empty, q_push, q_pop;
  task_t front_entry, back_entry;

  // Hold the configuration registers; take writes at any edge with the enable high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.load_res      <= LOAD_RES_RST;
      cfg_q.stable_needed <= STABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LOAD_RES: cfg_q.load_res      <= cfg_wdata_i;
        CFG_STABLE:   cfg_q.stable_needed <= cfg_wdata_i[STABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept and classify samples.
  rsc_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (front_entry)
  );

  // Decouple the two sides.
  rsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (back_entry)
  );

  // Convert, judge stability and deliver results.
  rsc_back #(
    .ADC_BITS (ADC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .entry_i     (back_entry),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// ----- design/rsc_checker.sv -----
// Port-level checker for the resistance settle calibrator, bound to the top level.
module rsc_checker import rsc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_stall_i,
  input out_item_t out_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_i))
    else $error("stalled result changed or dropped");

  // Report done only after at least one sample has been counted.
  a_done_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_i.done_res |-> out_i.settle_seconds != '0)
    else $error("done reported with zero sample count");

  // The first sample after reset or restart becomes the reference; once done,
  // later samples no longer touch it.
  a_first_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_i.done_res && out_i.settle_seconds == 16'd1 |->
      out_i.base_resistance == out_i.resistance)
    else $error("first sample not taken as reference");

  // Every result counts at least one sample.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_i.settle_seconds != '0)
    else $error("result with zero sample count");

endmodule

bind resistance_settle_calibrator rsc_checker u_rsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_i       (out_o)
);
